FILE: rtl/wfpa_pkg.sv
// Worst-fit partition allocator: shared package.
// Field widths, default parameters, command and status codes, control structs.
// No dependencies.
package wfpa_pkg;

	localparam int MAX_PARTS_DEF = 64;
	localparam int SIZE_BITS_DEF = 16;

	localparam int SLOT_W   = 6;
	localparam int AMOUNT_W = 16;
	localparam int COUNT_W  = 7;
	localparam int REQNUM_W = 8;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_LOADED  = 2'd0,
		STAT_GRANTED = 2'd1,
		STAT_NO_FIT  = 2'd2
	} status_t;

	// sequencer -> scan unit
	typedef struct packed {
		logic load;
		logic start;
		logic grant;
	} scan_ctrl_t;

	// scan unit -> sequencer
	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

FILE: rtl/wfpa_in_if.sv
// Input channel of the worst-fit partition allocator: command words.
// Depends on wfpa_pkg.
interface wfpa_in_if;
	logic                         valid;
	logic                         ready;
	wfpa_pkg::cmd_t               command;
	logic [wfpa_pkg::SLOT_W-1:0]  part_slot;
	logic [wfpa_pkg::AMOUNT_W-1:0] amount;

	modport source (output valid, output command, output part_slot, output amount,
		input ready);
	modport sink (input valid, input command, input part_slot, input amount,
		output ready);
endinterface

FILE: rtl/wfpa_out_if.sv
// Result channel of the worst-fit partition allocator.
// Depends on wfpa_pkg.
interface wfpa_out_if;
	logic                          valid;
	logic                          ready;
	wfpa_pkg::status_t             status;
	logic [wfpa_pkg::SLOT_W-1:0]   granted_slot;
	logic [wfpa_pkg::REQNUM_W-1:0] request_number;

	modport source (output valid, output status, output granted_slot,
		output request_number, input ready);
	modport sink (input valid, input status, input granted_slot,
		input request_number, output ready);
endinterface

FILE: rtl/wfpa_cfg_if.sv
// Configuration write channel: carries the partition count register.
// Depends on wfpa_pkg.
interface wfpa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [wfpa_pkg::COUNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/wfpa_scan.sv
// Partition table and scan unit: size/taken memory, one comparator walked
// over the partitions one per cycle, best-candidate tracking.
// Depends on wfpa_pkg.
module wfpa_scan #(
	parameter int MAX_PARTS = wfpa_pkg::MAX_PARTS_DEF,
	parameter int SIZE_BITS = wfpa_pkg::SIZE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_PARTS),
	localparam int LIM_W = IDX_W + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfpa_pkg::scan_ctrl_t ctrl,
	input  logic [IDX_W-1:0]     load_idx,
	input  logic [SIZE_BITS-1:0] amt,
	input  logic [LIM_W-1:0]     lim,
	output wfpa_pkg::scan_stat_t stat,
	output logic [IDX_W-1:0]     best_idx
);
	import wfpa_pkg::*;

	// word layout: taken flag on top, size below
	logic [SIZE_BITS:0]   mem [MAX_PARTS];

	logic                 scan_q;
	logic [LIM_W-1:0]     rd_idx_q;
	logic [LIM_W-1:0]     lim_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [SIZE_BITS:0]   data_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic                 done_q;

	logic                 issuing;
	logic                 take;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS:0]   wr_data;

	assign issuing = scan_q && (rd_idx_q < lim_q);

	// the shared comparator: fits, and strictly larger than the best so far
	assign take = vld_s1 && !data_s1[SIZE_BITS] && (data_s1[SIZE_BITS-1:0] >= amt_q)
		&& (!found_q || (data_s1[SIZE_BITS-1:0] > best_size_q));

	assign wr_en   = ctrl.load || ctrl.grant;
	assign wr_addr = ctrl.grant ? best_idx_q : load_idx;
	assign wr_data = ctrl.grant ? {1'b1, best_size_q} : {1'b0, amt};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (issuing) begin
			data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
			idx_s1  <= rd_idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= 1'b0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			vld_s1 <= issuing;
			done_q <= scan_q && !issuing;
			if (ctrl.start) begin
				scan_q   <= 1'b1;
				rd_idx_q <= '0;
				lim_q    <= lim;
				amt_q    <= amt;
				found_q  <= 1'b0;
			end else begin
				if (issuing)
					rd_idx_q <= rd_idx_q + 1'b1;
				else
					scan_q <= 1'b0;
				if (take) begin
					found_q     <= 1'b1;
					best_idx_q  <= idx_s1;
					best_size_q <= data_s1[SIZE_BITS-1:0];
				end
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign best_idx   = best_idx_q;

`ifndef ASSERT_OFF
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !vld_s1 && !scan_q)
		else $error("scan finished with a read still in flight");
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(scan_q))
		else $error("table read outside a scan");
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> best_size_q >= amt_q)
		else $error("chosen partition smaller than request");
	a_grant_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.grant |-> done_q && found_q)
		else $error("grant without a finished successful scan");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> !scan_q && !ctrl.grant)
		else $error("load collides with scan or grant");
`endif

endmodule

FILE: rtl/worst_fit_partition_allocator.sv
// Worst-fit partition allocator. One word is taken at a time. A load goes from
// acceptance through S_RESP into the output register; a request first scans N
// partitions, where N is partition_count held to at most MAX_PARTS, and the single
// read port of the partition table and the one comparator visit one partition per
// cycle. Each result waits in an output register; the input is ready again once that
// result has been placed there, so the next word can be accepted while the previous
// result still waits to be taken. The user must write partition_count through cfg
// only while idle; the block itself does not enforce it.
module worst_fit_partition_allocator #(
	parameter int MAX_PARTS = wfpa_pkg::MAX_PARTS_DEF,
	parameter int SIZE_BITS = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	wfpa_in_if.sink      in_ch,
	wfpa_out_if.source   out_ch,
	wfpa_cfg_if.sink     cfg
);
	import wfpa_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTS);
	localparam int LIM_W = IDX_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} fsm_t;

	fsm_t                state_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [REQNUM_W-1:0] req_cnt_q;
	logic [REQNUM_W-1:0] num_q;
	status_t             res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                accept;
	logic                slot_ok;
	logic [LIM_W-1:0]    lim;
	scan_ctrl_t          ctrl;
	scan_stat_t          stat;
	logic [IDX_W-1:0]    best_idx;

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_ok     = 32'(in_ch.part_slot) < MAX_PARTS;

	// hold the count to the table depth
	always_comb begin
		if (32'(cnt_q) > MAX_PARTS)
			lim = LIM_W'(MAX_PARTS);
		else
			lim = LIM_W'(cnt_q);
	end

	assign ctrl.load  = accept && (in_ch.command == CMD_LOAD) && slot_ok;
	assign ctrl.start = accept && (in_ch.command == CMD_REQUEST);
	assign ctrl.grant = (state_q == S_SCAN) && stat.done && stat.found;

	wfpa_scan #(
		.MAX_PARTS (MAX_PARTS),
		.SIZE_BITS (SIZE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.load_idx (IDX_W'(in_ch.part_slot)),
		.amt      (SIZE_BITS'(in_ch.amount)),
		.lim      (lim),
		.stat     (stat),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			req_cnt_q    <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg.valid)
				cnt_q <= cfg.data;
			if (out_ch.valid && out_ch.ready && state_q != S_RESP)
				out_ch.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_ch.command == CMD_LOAD) begin
							res_status_q <= STAT_LOADED;
							res_slot_q   <= '0;
							num_q        <= '0;
							state_q      <= S_RESP;
						end else begin
							num_q     <= req_cnt_q;
							req_cnt_q <= req_cnt_q + 1'b1;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (stat.done) begin
						res_status_q <= stat.found ? STAT_GRANTED : STAT_NO_FIT;
						res_slot_q   <= stat.found ? SLOT_W'(best_idx) : '0;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					// advance once the output register is free
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid          <= 1'b1;
						out_ch.status         <= res_status_q;
						out_ch.granted_slot   <= res_slot_q;
						out_ch.request_number <= num_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
